>>> hdl/wsc_pkg.sv
// Shared types and codes for the wildcard signature scanner.
package wsc_pkg;

  // Input word modes.
  localparam logic [1:0] MODE_PAT  = 2'd0;
  localparam logic [1:0] MODE_CODE = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_FOUND   = 2'd1;
  localparam logic [1:0] ST_SKIPPED = 2'd2;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_EP_ONLY   = 2'd0;
  localparam logic [1:0] REG_FULL_SCAN = 2'd1;
  localparam logic [1:0] REG_ENTRY     = 2'd2;

  localparam int CFG_ADDR_W = 4;

  // Current register contents as seen by the datapath.
  typedef struct packed {
    logic        ep_only;
    logic        full_scan;
    logic [31:0] entry_offset;
  } cfg_t;

  // Per-cycle control shared by every cell of the chain.
  typedef struct packed {
    logic code_shift;
    logic pat_shift;
    logic cmp_en;
  } cell_ctl_t;

endpackage

>>> hdl/wsc_if.sv
// Valid/ready channel interfaces for the scanner's input and result words.
interface wsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [3:0] nibble;
  logic       wildcard_req;

  modport source(output valid, mode, nibble, wildcard_req, input ready);
  modport sink(input valid, mode, nibble, wildcard_req, output ready);
endinterface

interface wsc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] match_offset;

  modport source(output valid, status, match_offset, input ready);
  modport sink(input valid, status, match_offset, output ready);
endinterface

>>> hdl/wsc_cfg.sv
// APB-style register file holding the scanner's configuration registers.
module wsc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wsc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output wsc_pkg::cfg_t                     cfg
);

  wsc_pkg::cfg_t cfg_r;
  logic          wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ep_only      <= 1'b0;
      cfg_r.full_scan    <= 1'b1;
      cfg_r.entry_offset <= 32'd0;
    end else if (wr) begin
      case (paddr[3:2])
        wsc_pkg::REG_EP_ONLY:   cfg_r.ep_only      <= pwdata[0];
        wsc_pkg::REG_FULL_SCAN: cfg_r.full_scan    <= pwdata[0];
        wsc_pkg::REG_ENTRY:     cfg_r.entry_offset <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wsc_pkg::REG_EP_ONLY:   prdata = {31'd0, cfg_r.ep_only};
      wsc_pkg::REG_FULL_SCAN: prdata = {31'd0, cfg_r.full_scan};
      wsc_pkg::REG_ENTRY:     prdata = cfg_r.entry_offset;
      default:                prdata = 32'd0;
    endcase
  end

endmodule

>>> hdl/wsc_cell.sv
// One cell of the match chain: a code nibble, a signature nibble and a compare.
module wsc_cell (
  input  logic                clk,
  input  wsc_pkg::cell_ctl_t  ctl,
  input  logic [3:0]          code_in,
  input  logic [3:0]          dig_in,
  input  logic                wild_in,
  input  logic                active,
  output logic [3:0]          code_q,
  output logic [3:0]          dig_q,
  output logic                wild_q,
  output logic                hit_q
);

  logic [3:0] code_r;
  logic [3:0] dig_r;
  logic       wild_r;
  logic       hit_r;
  logic       hit_nxt;

  // A cell beyond the signature length never blocks a match.
  assign hit_nxt = !active || wild_r || (dig_r == code_r);

  always_ff @(posedge clk) begin
    if (ctl.code_shift) begin
      code_r <= code_in;
    end
    if (ctl.pat_shift) begin
      dig_r  <= dig_in;
      wild_r <= wild_in;
    end
    if (ctl.cmp_en) begin
      hit_r <= hit_nxt;
    end
  end

  assign code_q = code_r;
  assign dig_q  = dig_r;
  assign wild_q = wild_r;
  assign hit_q  = hit_r;

endmodule

>>> hdl/wildcard_signature_scanner.sv
// Wildcard signature scanner: a chain of compare cells taking one word per cycle.
// Throughput: one word per cycle; the input stalls only while an end-of-image verdict waits
// in step B and the output register holds a word that is not taken in that cycle.
// A result word is valid once its end word has passed steps A and B into the output register;
// the three-step pipeline is update chain, per-cell compare, combine and verdict.
// Reset (synchronous, active low) clears scan state and valids and restores register defaults.
module wildcard_signature_scanner #(
  parameter int MAX_PATTERN_NIBBLES = 64,
  parameter int OFFSET_BITS         = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  wsc_in_if.sink                          in_if,
  wsc_out_if.source                       out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wsc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int N  = MAX_PATTERN_NIBBLES;
  localparam int CW = $clog2(N + 1);
  localparam int OB = OFFSET_BITS;
  localparam int PW = OFFSET_BITS + 1;
  localparam logic [PW-1:0] POS_MAX  = {PW{1'b1}};
  localparam logic [CW-1:0] CNT_FULL = CW'(N);

  // Configuration registers.
  wsc_pkg::cfg_t cfg;

  wsc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Scan state.
  logic [CW-1:0] count_r;
  logic [PW-1:0] pos_r;
  logic          found_r;
  logic [OB-1:0] found_off_r;

  // Pipeline registers. Step A holds a word whose chain update has just happened; step B
  // holds the same word while the cells' registered compare results are available.
  logic          a_vld_r, a_end_r, a_fix_r;
  logic [1:0]    a_fix_st_r;
  logic [PW-1:0] a_start_r;
  logic          b_vld_r, b_end_r, b_fix_r;
  logic [1:0]    b_fix_st_r;
  logic [PW-1:0] b_start_r;

  // Output register.
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_off_r;

  // The whole pipeline moves together. It holds only when an end-of-image verdict is
  // ready to leave step B and the output register still holds an untaken word.
  logic en, acc, is_pat, is_code, is_end;
  logic pat_take, code_take;

  assign en      = !(out_valid_r && !out_if.ready && b_vld_r && b_end_r);
  assign in_if.ready = en;
  assign acc     = in_if.valid && en;
  assign is_pat  = acc && (in_if.mode == wsc_pkg::MODE_PAT);
  assign is_code = acc && (in_if.mode == wsc_pkg::MODE_CODE);
  assign is_end  = acc && (in_if.mode == wsc_pkg::MODE_END);

  // Signature nibbles past the chain's length are dropped; code nibbles stop once the
  // position counter is saturated.
  assign pat_take  = is_pat && (count_r != CNT_FULL);
  assign code_take = is_code && (pos_r != POS_MAX);

  // Candidate start for the window that ends at the incoming code nibble.
  logic [PW-1:0]   pos_inc;
  logic [PW:0]     diff;
  logic [PW-1:0]   start;
  logic            fits;
  logic [OB+31:0]  ent_wide;
  logic [PW-1:0]   ent_start;
  logic            mode_ok, elig;

  assign pos_inc   = pos_r + 1'b1;
  assign diff      = {1'b0, pos_inc} - {{(PW + 1 - CW){1'b0}}, count_r};
  assign start     = diff[PW-1:0];
  assign fits      = !diff[PW];
  assign ent_wide  = {{OB{1'b0}}, cfg.entry_offset};
  assign ent_start = {ent_wide[OB-1:0], 1'b0};
  assign mode_ok   = cfg.ep_only ? (start == ent_start) : cfg.full_scan;
  assign elig      = code_take && (count_r != '0) && fits && !start[0] && mode_ok;

  // Parts of the end-of-image verdict that do not depend on the found flag are settled
  // here, against the state before the end word clears it.
  logic       skipped, empty, ep_reach;
  logic       fix_nxt;
  logic [1:0] fix_st_nxt;

  assign skipped  = !cfg.ep_only && !cfg.full_scan;
  assign empty    = (count_r == '0);
  assign ep_reach = (ent_start <= pos_r);
  assign fix_nxt  = skipped || empty;

  always_comb begin
    if (skipped) begin
      fix_st_nxt = wsc_pkg::ST_SKIPPED;
    end else if (cfg.ep_only && !ep_reach) begin
      fix_st_nxt = wsc_pkg::ST_NONE;
    end else begin
      fix_st_nxt = wsc_pkg::ST_FOUND;
    end
  end

  // Length and position. An end word clears them at once, so the words that follow
  // start a fresh signature while the verdict is still in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pos_r   <= '0;
    end else if (is_end) begin
      count_r <= '0;
      pos_r   <= '0;
    end else if (pat_take) begin
      count_r <= count_r + 1'b1;
    end else if (code_take) begin
      pos_r <= pos_inc;
    end
  end

  // The chain of cells. Cell j holds code nibble j back from the newest and signature
  // nibble j back from the last one loaded, so cell j compares signature nibble
  // (length-1-j) against the code nibble at that place of the window.
  wsc_pkg::cell_ctl_t ctl;
  logic [3:0]         code_w [N];
  logic [3:0]         dig_w  [N];
  logic               wild_w [N];
  logic [N-1:0]       hits;

  assign ctl.code_shift = code_take;
  assign ctl.pat_shift  = pat_take;
  assign ctl.cmp_en     = en;

  for (genvar j = 0; j < N; j++) begin : g_cell
    logic [3:0] code_in;
    logic [3:0] dig_in;
    logic       wild_in;

    if (j == 0) begin : g_head
      assign code_in = in_if.nibble;
      assign dig_in  = in_if.nibble;
      assign wild_in = in_if.wildcard_req;
    end else begin : g_link
      assign code_in = code_w[j-1];
      assign dig_in  = dig_w[j-1];
      assign wild_in = wild_w[j-1];
    end

    wsc_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .code_in (code_in),
      .dig_in  (dig_in),
      .wild_in (wild_in),
      .active  (count_r > CW'(j)),
      .code_q  (code_w[j]),
      .dig_q   (dig_w[j]),
      .wild_q  (wild_w[j]),
      .hit_q   (hits[j])
    );
  end

  // Step A captures eligible code words and end words; everything else needs no verdict.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= elig || is_end;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_end_r    <= is_end;
      a_fix_r    <= fix_nxt;
      a_fix_st_r <= fix_st_nxt;
      a_start_r  <= is_end ? (cfg.ep_only ? ent_start : '0) : start;
      b_end_r    <= a_end_r;
      b_fix_r    <= a_fix_r;
      b_fix_st_r <= a_fix_st_r;
      b_start_r  <= a_start_r;
    end
  end

  // Step B: combine the cells' compare results. The first eligible match wins; an end
  // word reads the found flag after every earlier code word has updated it, then clears it.
  logic          all_hit;
  logic [1:0]    res_st;
  logic [OB-1:0] res_off;
  logic [OB+31:0] res_wide;

  assign all_hit = &hits;

  always_comb begin
    if (b_fix_r) begin
      res_st  = b_fix_st_r;
      res_off = (b_fix_st_r == wsc_pkg::ST_FOUND) ? b_start_r[PW-1:1] : '0;
    end else if (found_r) begin
      res_st  = wsc_pkg::ST_FOUND;
      res_off = found_off_r;
    end else begin
      res_st  = wsc_pkg::ST_NONE;
      res_off = '0;
    end
  end

  assign res_wide = {32'd0, res_off};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (en && b_vld_r) begin
      if (b_end_r) begin
        found_r <= 1'b0;
      end else if (!found_r && all_hit) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && b_vld_r && !b_end_r && !found_r && all_hit) begin
      found_off_r <= b_start_r[PW-1:1];
    end
  end

  // Output register: loads a verdict word, drops it once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && b_vld_r && b_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && b_vld_r && b_end_r) begin
      out_status_r <= res_st;
      out_off_r    <= res_wide[31:0];
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.match_offset = out_off_r;

endmodule

>>> sim/tb_wildcard_signature_scanner.sv
// Self-checking testbench for the wildcard signature scanner: directed and random words.
`timescale 1ns / 1ps

module tb_wildcard_signature_scanner;

  // The fourth mode encoding carries no meaning; the scanner must drop such words.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Depth of the signature store and the code history, as in the default build.
  localparam int          PAT_DEPTH   = 64;
  // The nibble position is one bit wider than a byte offset and saturates at all ones.
  localparam logic [32:0] POS_LIMIT   = '1;
  // The slowest correct run stays well inside this limit, leaving ample headroom.
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          WORD_TARGET = 1400;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] nibble;
    logic       wild;
  } scan_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] offset;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [wsc_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  wsc_in_if  scan_in();
  wsc_out_if scan_out();

  wildcard_signature_scanner u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (scan_in),
    .out_if  (scan_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be offered, and verdicts the scanner still owes us.
  scan_word_t  words_to_send[$];
  verdict_t    verdicts_due[$];
  int unsigned words_queued;
  int unsigned errors;
  int unsigned cycles;

  // Idle draws: the largest idle gap each side draws per word. Zero gives back-to-back traffic.
  int unsigned in_gap_max;
  int unsigned out_gap_max;
  int unsigned send_gap;
  int unsigned recv_hold;

  // Our own copy of the register file.
  logic        cfg_ep_only;
  logic        cfg_full_scan;
  logic [31:0] cfg_entry;

  // Our own copy of the scan state. code_hist[0] is the newest code nibble.
  logic [3:0]  sig_digit [PAT_DEPTH];
  logic        sig_wild  [PAT_DEPTH];
  int unsigned sig_len;
  logic [3:0]  code_hist [PAT_DEPTH];
  logic [32:0] code_pos;
  logic        found_seen;
  logic [31:0] found_byte;

  // An end word wipes the signature and the whole scan; the registers survive.
  function automatic void clear_scan_state();
    sig_len    = 0;
    code_pos   = '0;
    found_seen = 1'b0;
    found_byte = '0;
    for (int k = 0; k < PAT_DEPTH; k++) begin
      code_hist[k] = 4'd0;
      sig_digit[k] = 4'd0;
      sig_wild[k]  = 1'b0;
    end
  endfunction

  // Advances our copy of the scanner by one accepted word and queues the verdict
  // that an end word must produce.
  task automatic track_scan_word(input scan_word_t w);
    logic [32:0] start;
    logic        hit;
    verdict_t    v;
    int          k;
    case (w.mode)
      wsc_pkg::MODE_PAT: begin
        // Signature digits past the store's depth are silently dropped.
        if (sig_len < PAT_DEPTH) begin
          sig_digit[sig_len] = w.nibble;
          sig_wild[sig_len]  = w.wild;
          sig_len++;
        end
      end
      wsc_pkg::MODE_CODE: begin
        if (code_pos != POS_LIMIT) begin
          for (k = PAT_DEPTH - 1; k > 0; k--) code_hist[k] = code_hist[k - 1];
          code_hist[0] = w.nibble;
          code_pos++;
          // A start is tested once the whole signature lies inside the code seen so far.
          // Only byte-aligned starts count, and in entry mode only the entry point.
          if (!found_seen && sig_len != 0 && code_pos >= sig_len) begin
            start = code_pos - sig_len;
            if (!start[0] && (cfg_ep_only ? (start == {cfg_entry, 1'b0}) : cfg_full_scan)) begin
              hit = 1'b1;
              for (k = 0; k < sig_len; k++) begin
                if (!sig_wild[k] && sig_digit[k] != code_hist[sig_len - 1 - k]) hit = 1'b0;
              end
              if (hit) begin
                found_seen = 1'b1;
                found_byte = start[32:1];
              end
            end
          end
        end
      end
      wsc_pkg::MODE_END: begin
        v.status = wsc_pkg::ST_NONE;
        v.offset = '0;
        if (!cfg_ep_only && !cfg_full_scan) begin
          // No entry-only signature and no permission for a full scan.
          v.status = wsc_pkg::ST_SKIPPED;
        end else if (sig_len == 0) begin
          // An empty signature hits the entry point if the code reached it,
          // or the very first byte in a full scan.
          if (cfg_ep_only) begin
            if ({cfg_entry, 1'b0} <= code_pos) begin
              v.status = wsc_pkg::ST_FOUND;
              v.offset = cfg_entry;
            end
          end else begin
            v.status = wsc_pkg::ST_FOUND;
          end
        end else if (found_seen) begin
          v.status = wsc_pkg::ST_FOUND;
          v.offset = found_byte;
        end
        verdicts_due.push_back(v);
        clear_scan_state();
      end
      default: ;
    endcase
  endtask

  // Driver: offers the pending words one by one and predicts each one as it is accepted.
  always @(posedge clk) begin : word_driver
    scan_word_t nxt;
    scan_word_t got;
    logic       launch;
    if (!rst_n) begin
      scan_in.valid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (scan_in.valid && scan_in.ready) begin
        got.mode   = scan_in.mode;
        got.nibble = scan_in.nibble;
        got.wild   = scan_in.wildcard_req;
        track_scan_word(got);
      end
      // The slot frees up when nothing is offered or the offered word was just taken.
      if (!scan_in.valid || scan_in.ready) begin
        launch = 1'b0;
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (words_to_send.size() != 0) begin
          nxt                  = words_to_send.pop_front();
          launch               = 1'b1;
          scan_in.mode         <= nxt.mode;
          scan_in.nibble       <= nxt.nibble;
          scan_in.wildcard_req <= nxt.wild;
          send_gap             <= $urandom_range(0, in_gap_max);
        end
        scan_in.valid <= launch;
      end
    end
  end

  // Monitor: stalls at random and compares every result word with the oldest verdict due.
  always @(posedge clk) begin : verdict_monitor
    verdict_t    want;
    int unsigned hold;
    if (!rst_n) begin
      scan_out.ready <= 1'b0;
      recv_hold      <= 0;
    end else begin
      hold = recv_hold;
      if (scan_out.valid && scan_out.ready) begin
        hold = $urandom_range(0, out_gap_max);
        if (verdicts_due.size() == 0) begin
          $display("%0t: result word with none due: status %0d offset %0h", $time,
                   scan_out.status, scan_out.match_offset);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (scan_out.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     want.status, scan_out.status);
            errors++;
          end
          if (scan_out.match_offset !== want.offset) begin
            $display("%0t: match_offset mismatch: expected %0h actual %0h", $time,
                     want.offset, scan_out.match_offset);
            errors++;
          end
        end
      end
      if (hold != 0) begin
        scan_out.ready <= 1'b0;
        recv_hold      <= hold - 1;
      end else begin
        scan_out.ready <= 1'b1;
        recv_hold      <= 0;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_word(input logic [1:0] mode, input logic [3:0] nibble, input logic wild);
    scan_word_t w;
    w.mode   = mode;
    w.nibble = nibble;
    w.wild   = wild;
    words_to_send.push_back(w);
    if (mode != MODE_UNUSED) words_queued++;
  endtask

  // Waits, at falling edges so that all updates of the rising edge have landed, until
  // every word is sent and every verdict is in, then lets the pipeline drain.
  task automatic settle();
    do @(negedge clk);
    while (words_to_send.size() != 0 || scan_in.valid || verdicts_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready is seen.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      wsc_pkg::REG_EP_ONLY:   cfg_ep_only   = val[0];
      wsc_pkg::REG_FULL_SCAN: cfg_full_scan = val[0];
      wsc_pkg::REG_ENTRY:     cfg_entry     = val;
      default: ;
    endcase
  endtask

  // One code image: a signature, code with the signature planted in it now and then,
  // a little noise, and usually an end word.
  task automatic queue_image();
    logic [3:0]  sig_nib [80];
    logic        sig_any [80];
    logic [3:0]  img [200];
    int unsigned plen, used, clen, at, k, r;
    r = $urandom_range(0, 99);
    if (r < 5) plen = 0;
    else if (r < 85) plen = $urandom_range(1, 8);
    else if (r < 96) plen = $urandom_range(9, PAT_DEPTH);
    else plen = $urandom_range(PAT_DEPTH + 1, PAT_DEPTH + 8);
    used = (plen > PAT_DEPTH) ? PAT_DEPTH : plen;
    for (k = 0; k < plen; k++) begin
      sig_nib[k] = 4'($urandom_range(0, 15));
      sig_any[k] = ($urandom_range(0, 3) == 0);
    end
    for (k = 0; k < 200; k++) img[k] = 4'($urandom_range(0, 15));
    clen = used + $urandom_range(0, 24);
    if ($urandom_range(0, 9) == 0) clen = $urandom_range(0, 3);
    // Plant copies of the signature. In entry mode aim at the entry point most of the
    // time; otherwise pick a start that is usually even, sometimes odd.
    repeat ($urandom_range(0, 2)) begin
      if (cfg_ep_only && cfg_entry < 40 && $urandom_range(0, 3) != 0) begin
        at = 2 * cfg_entry;
      end else begin
        at = $urandom_range(0, 20);
        if ($urandom_range(0, 4) != 0) at = at & ~32'd1;
      end
      if (at + used > clen) clen = at + used;
      for (k = 0; k < used; k++) img[at + k] = sig_any[k] ? img[at + k] : sig_nib[k];
    end
    for (k = 0; k < plen; k++) queue_word(wsc_pkg::MODE_PAT, sig_nib[k], sig_any[k]);
    for (k = 0; k < clen; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        queue_word(MODE_UNUSED, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end else if (r < 5) begin
        queue_word(wsc_pkg::MODE_PAT, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
      queue_word(wsc_pkg::MODE_CODE, img[k], 1'($urandom_range(0, 1)));
    end
    // Now and then the image runs on into the next one without an end word.
    if ($urandom_range(0, 19) != 0) begin
      queue_word(wsc_pkg::MODE_END, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    scan_in.valid        = 1'b0;
    scan_in.mode         = wsc_pkg::MODE_PAT;
    scan_in.nibble       = 4'd0;
    scan_in.wildcard_req = 1'b0;
    scan_out.ready       = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    words_queued         = 0;
    errors               = 0;
    cycles               = 0;
    in_gap_max           = 19;
    out_gap_max          = 19;
    cfg_ep_only          = 1'b0;
    cfg_full_scan        = 1'b1;
    cfg_entry            = '0;
    clear_scan_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full scan with reset settings. "F?" misses at byte 0 and hits at byte 1,
    // with a word of the unused mode mixed in.
    queue_word(wsc_pkg::MODE_PAT, 4'hF, 1'b0);
    queue_word(wsc_pkg::MODE_PAT, 4'h0, 1'b1);
    queue_word(MODE_UNUSED, 4'hF, 1'b1);
    queue_word(wsc_pkg::MODE_CODE, 4'h0, 1'b0);
    queue_word(wsc_pkg::MODE_CODE, 4'hF, 1'b1);
    queue_word(wsc_pkg::MODE_CODE, 4'hF, 1'b0);
    queue_word(wsc_pkg::MODE_CODE, 4'h0, 1'b0);
    queue_word(wsc_pkg::MODE_END, 4'h0, 1'b0);
    // An empty signature in a full scan is found at byte 0.
    queue_word(wsc_pkg::MODE_END, 4'hF, 1'b1);
    // A plain miss.
    queue_word(wsc_pkg::MODE_PAT, 4'h0, 1'b0);
    queue_word(wsc_pkg::MODE_CODE, 4'h1, 1'b0);
    queue_word(wsc_pkg::MODE_END, 4'h0, 1'b0);
    settle();

    // Entry mode at byte 1: an empty signature is found when the code reaches the
    // entry point, and a one-digit signature is tested only there.
    reg_write(wsc_pkg::REG_EP_ONLY, 32'd1);
    reg_write(wsc_pkg::REG_ENTRY, 32'd1);
    queue_word(wsc_pkg::MODE_CODE, 4'h3, 1'b0);
    queue_word(wsc_pkg::MODE_CODE, 4'hC, 1'b0);
    queue_word(wsc_pkg::MODE_END, 4'h0, 1'b0);
    queue_word(wsc_pkg::MODE_PAT, 4'hA, 1'b0);
    queue_word(wsc_pkg::MODE_CODE, 4'hA, 1'b0);
    queue_word(wsc_pkg::MODE_CODE, 4'h0, 1'b0);
    queue_word(wsc_pkg::MODE_CODE, 4'hA, 1'b0);
    queue_word(wsc_pkg::MODE_END, 4'h0, 1'b0);
    settle();

    // Entry point at the largest offset: an empty signature lies beyond the code.
    reg_write(wsc_pkg::REG_ENTRY, 32'hFFFF_FFFF);
    queue_word(wsc_pkg::MODE_END, 4'h0, 1'b0);
    settle();

    // Neither entry-only nor full scan: the image is not scanned.
    reg_write(wsc_pkg::REG_EP_ONLY, 32'd0);
    reg_write(wsc_pkg::REG_FULL_SCAN, 32'd0);
    queue_word(wsc_pkg::MODE_END, 4'h0, 1'b0);
    settle();

    // Random phases. Between phases the sender holds off until every verdict is in,
    // then the registers and both idle profiles are redrawn.
    while (words_queued < WORD_TARGET) begin
      if ($urandom_range(0, 3) != 0) begin
        reg_write(wsc_pkg::REG_EP_ONLY, $urandom_range(0, 1));
      end
      if ($urandom_range(0, 3) != 0) begin
        reg_write(wsc_pkg::REG_FULL_SCAN, 32'($urandom_range(0, 3) != 0));
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       reg_write(wsc_pkg::REG_ENTRY, 32'd0);
          1:       reg_write(wsc_pkg::REG_ENTRY, 32'hFFFF_FFFF);
          2:       reg_write(wsc_pkg::REG_ENTRY, 32'h8000_0000);
          default: reg_write(wsc_pkg::REG_ENTRY, $urandom_range(0, 12));
        endcase
      end
      in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 19;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
      @(negedge clk);
      repeat ($urandom_range(3, 8)) queue_image();
      settle();
    end

    repeat (10) @(negedge clk);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> wildcard_signature_scanner.f
hdl/wsc_pkg.sv
hdl/wsc_if.sv
hdl/wsc_cfg.sv
hdl/wsc_cell.sv
hdl/wildcard_signature_scanner.sv
sim/tb_wildcard_signature_scanner.sv
